// ===== sv/sqltl_pkg.sv =====
// Shared record and bundle types for the SQL token lexer.
package sqltl_pkg;

  localparam int MAX_RECS  = 4;
  localparam int REC_IDX_W = $clog2(MAX_RECS);
  localparam int REC_CNT_W = $clog2(MAX_RECS + 1);

  localparam logic [1:0] REC_TEXT  = 2'd0;
  localparam logic [1:0] REC_TOKEN = 2'd1;
  localparam logic [1:0] REC_END   = 2'd2;

  typedef struct packed {
    logic [1:0] rec_type;
    logic [7:0] text_byte;
    logic [4:0] kind;
  } rec_t;

  // All records caused by one input word, in output order.
  typedef struct packed {
    logic [REC_CNT_W-1:0]   count;
    rec_t [MAX_RECS-1:0]    recs;
  } bundle_t;

endpackage

// ===== sv/sqltl_front.sv =====
// Lexer front end: accepts statement bytes and builds the record bundle for each.
module sqltl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        ch,
  input  logic              end_of_statement,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  logic              q_full,
  output logic              q_push,
  output sqltl_pkg::bundle_t q_data
);
  import sqltl_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_WORD, M_NUM, M_STR, M_LESS, M_SKIP} mode_t;

  localparam int NUM_KW = 18;
  localparam logic [NUM_KW-1:0] ALL_KW = '1;

  localparam logic [4:0] K_ID     = 5'd0;
  localparam logic [4:0] K_NUM    = 5'd1;
  localparam logic [4:0] K_STR    = 5'd2;
  localparam logic [4:0] K_KW0    = 5'd3;
  localparam logic [4:0] K_STAR   = 5'd21;
  localparam logic [4:0] K_DOT    = 5'd22;
  localparam logic [4:0] K_COMMA  = 5'd23;
  localparam logic [4:0] K_NE     = 5'd24;
  localparam logic [4:0] K_LT     = 5'd25;
  localparam logic [4:0] K_GT     = 5'd26;
  localparam logic [4:0] K_EQ     = 5'd27;
  localparam logic [4:0] K_LPAREN = 5'd28;
  localparam logic [4:0] K_RPAREN = 5'd29;
  localparam logic [4:0] K_SEMI   = 5'd30;
  localparam logic [4:0] K_ERR    = 5'd31;

  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // Keywords in alphabetical order, right-justified text.
  localparam logic [55:0] KW_WORD [NUM_KW] = '{
    "and", "as", "by", "create", "delete", "false", "from", "insert", "into",
    "join", "order", "select", "set", "table", "true", "update", "values", "where"
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd2, 3'd2, 3'd6, 3'd6, 3'd5, 3'd4, 3'd6, 3'd4,
    3'd4, 3'd5, 3'd6, 3'd3, 3'd5, 3'd4, 3'd6, 3'd6, 3'd5
  };

  typedef struct packed {
    logic [NUM_KW-1:0] km;
    logic [2:0]        wl;
  } match_t;

  function automatic logic [7:0] kw_char(int k, logic [2:0] p);
    int sh;
    sh = 8 * (int'(KW_LEN[k]) - 1 - int'(p));
    if (p < KW_LEN[k]) return KW_WORD[k][sh +: 8];
    return 8'h00;
  endfunction

  // One letter of a word narrows the candidate keyword set.
  function automatic match_t match_step(logic [NUM_KW-1:0] km, logic [2:0] wl,
                                        logic [7:0] c);
    match_t r;
    r.km = km;
    r.wl = wl;
    if (wl != 3'd7) begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (kw_char(k, wl) != c) r.km[k] = 1'b0;
      end
      r.wl = wl + 3'd1;
    end else begin
      r.km = '0;
    end
    return r;
  endfunction

  function automatic logic [4:0] word_kind(logic [NUM_KW-1:0] km, logic [2:0] wl);
    logic [4:0] r;
    r = K_ID;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (km[k] && (KW_LEN[k] == wl)) r = 5'(int'(K_KW0) + k);
    end
    return r;
  endfunction

  function automatic logic [4:0] special_kind(logic [7:0] c);
    case (c)
      "*":     return K_STAR;
      ".":     return K_DOT;
      ",":     return K_COMMA;
      ">":     return K_GT;
      "=":     return K_EQ;
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      ";":     return K_SEMI;
      default: return K_ERR;
    endcase
  endfunction

  function automatic bundle_t push_rec(bundle_t b, logic [1:0] t, logic [7:0] d,
                                       logic [4:0] k);
    bundle_t r;
    r = b;
    r.recs[b.count[REC_IDX_W-1:0]] = '{rec_type: t, text_byte: d, kind: k};
    r.count = b.count + 1'b1;
    return r;
  endfunction

  mode_t             lex_mode, lex_mode_next;
  logic [NUM_KW-1:0] keyword_match, keyword_match_next;
  logic [2:0]        word_length, word_length_next;
  bundle_t           b;
  match_t            step;
  logic              used;
  logic              accept;
  logic              is_letter, is_digit;
  logic [4:0]        sk;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign is_letter  = ch inside {["a":"z"], ["A":"Z"]};
  assign is_digit   = ch inside {["0":"9"]};
  assign sk         = special_kind(ch);

  always_comb begin
    lex_mode_next      = lex_mode;
    keyword_match_next = keyword_match;
    word_length_next   = word_length;
    b                  = '0;
    used               = 1'b0;
    step               = '0;

    case (lex_mode)
      M_SKIP: used = 1'b1;
      M_STR: begin
        if (ch == CH_QUOTE) begin
          b = push_rec(b, REC_TOKEN, 8'h00, K_STR);
          lex_mode_next = M_IDLE;
        end else begin
          b = push_rec(b, REC_TEXT, ch, K_ID);
        end
        used = 1'b1;
      end
      M_WORD: begin
        if (is_letter || ch == CH_UNDER || ch == CH_DASH) begin
          b = push_rec(b, REC_TEXT, ch, K_ID);
          step = match_step(keyword_match, word_length, ch);
          keyword_match_next = step.km;
          word_length_next   = step.wl;
          used = 1'b1;
        end else begin
          b = push_rec(b, REC_TOKEN, 8'h00, word_kind(keyword_match, word_length));
          lex_mode_next = M_IDLE;
        end
      end
      M_NUM: begin
        if (is_digit) begin
          b = push_rec(b, REC_TEXT, ch, K_ID);
          used = 1'b1;
        end else begin
          b = push_rec(b, REC_TOKEN, 8'h00, K_NUM);
          lex_mode_next = M_IDLE;
        end
      end
      M_LESS: begin
        lex_mode_next = M_IDLE;
        if (ch == CH_GT) begin
          b = push_rec(b, REC_TOKEN, 8'h00, K_NE);
          used = 1'b1;
        end else begin
          b = push_rec(b, REC_TOKEN, 8'h00, K_LT);
        end
      end
      default: lex_mode_next = M_IDLE;
    endcase

    // The byte was not consumed by an open token: unless it is whitespace, it starts a new one.
    if (!used) begin
      if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR) begin
        lex_mode_next = M_IDLE;
      end else if (ch == CH_QUOTE) begin
        lex_mode_next = M_STR;
      end else if (is_letter) begin
        step = match_step(ALL_KW, 3'd0, ch);
        keyword_match_next = step.km;
        word_length_next   = step.wl;
        b = push_rec(b, REC_TEXT, ch, K_ID);
        lex_mode_next = M_WORD;
      end else if (is_digit) begin
        b = push_rec(b, REC_TEXT, ch, K_ID);
        lex_mode_next = M_NUM;
      end else if (ch == CH_LT) begin
        lex_mode_next = M_LESS;
      end else begin
        b = push_rec(b, REC_TOKEN, 8'h00, sk);
        if (sk == K_ERR) lex_mode_next = M_SKIP;
      end
    end

    // Close any open token, mark the statement end and start over.
    if (end_of_statement) begin
      case (lex_mode_next)
        M_WORD:  b = push_rec(b, REC_TOKEN, 8'h00,
                              word_kind(keyword_match_next, word_length_next));
        M_NUM:   b = push_rec(b, REC_TOKEN, 8'h00, K_NUM);
        M_STR:   b = push_rec(b, REC_TOKEN, 8'h00, K_STR);
        M_LESS:  b = push_rec(b, REC_TOKEN, 8'h00, K_LT);
        default: ;
      endcase
      b = push_rec(b, REC_END, 8'h00, K_ID);
      lex_mode_next      = M_IDLE;
      keyword_match_next = ALL_KW;
      word_length_next   = 3'd0;
    end
  end

  assign q_push = accept && (b.count != '0);
  assign q_data = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode      <= M_IDLE;
      keyword_match <= ALL_KW;
      word_length   <= 3'd0;
    end else if (accept) begin
      lex_mode      <= lex_mode_next;
      keyword_match <= keyword_match_next;
      word_length   <= word_length_next;
    end
  end

`ifndef SYNTH
  // After an error, bytes before the statement end must produce nothing.
  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && lex_mode == M_SKIP && !end_of_statement) |-> !q_push)
    else $error("record produced while skipping after an error");
`endif

endmodule

// ===== sv/sqltl_queue.sv =====
// Short bundle queue between the lexer front end and the record output stage.
module sqltl_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sqltl_pkg::bundle_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output sqltl_pkg::bundle_t head
);
  import sqltl_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   fill;

  assign full       = (fill == CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("bundle queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("bundle queue read while empty");
`endif

endmodule

// ===== sv/sqltl_back.sv =====
// Record output stage: drains queued bundles one record per cycle while rec_ready allows.
module sqltl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  sqltl_pkg::bundle_t q_head,
  output logic               q_pop,
  output logic               rec_valid,
  input  logic               rec_ready,
  output logic [1:0]         rec_type,
  output logic [7:0]         text_byte,
  output logic [4:0]         kind,
  output logic               last
);
  import sqltl_pkg::*;

  logic [REC_IDX_W-1:0] idx;
  rec_t                 cur;
  logic                 load;
  logic                 at_end;

  assign load   = q_valid && (!rec_valid || rec_ready);
  assign cur    = q_head.recs[idx];
  assign at_end = ({1'b0, idx} == REC_CNT_W'(q_head.count - 1'b1));
  assign q_pop  = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      rec_valid <= 1'b1;
      idx       <= at_end ? '0 : idx + 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_type  <= cur.rec_type;
      text_byte <= cur.text_byte;
      kind      <= cur.kind;
      last      <= at_end;
    end
  end

`ifndef SYNTH
  // A statement end is always the final record of its input word.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_type == REC_END) |-> last)
    else $error("statement end record not marked last");
`endif

endmodule

// ===== sv/sql_token_lexer.sv =====
// Streaming SQL tokenizer top level: front end, bundle queue and record output.
// The first record caused by an accepted byte goes through a queue slot and then the
// registered output word. A byte is accepted every cycle while the bundle queue has room;
// the output port moves one record per cycle while rec_ready allows, a byte causes 0 to 4
// records, and QDEPTH bundles absorb the difference between the two sides.
// Reset (synchronous, rst high) returns the lexer to idle and empties the queue and output.
module sql_token_lexer #(
  parameter int QDEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ch,
  input  logic       end_of_statement,
  input  logic       byte_valid,
  output logic       byte_ready,
  output logic       rec_valid,
  input  logic       rec_ready,
  output logic [1:0] rec_type,
  output logic [7:0] text_byte,
  output logic [4:0] kind,
  output logic       last
);
  import sqltl_pkg::*;

  // Every accepted word is classified in the cycle it arrives. The records it causes
  // (text bytes, token kinds, the statement end) are gathered into one bundle, which
  // enters the queue only if it holds at least one record.
  bundle_t push_data, head;
  logic    push, full, pop, head_valid;

  sqltl_front u_front (
    .clk              (clk),
    .rst              (rst),
    .ch               (ch),
    .end_of_statement (end_of_statement),
    .byte_valid       (byte_valid),
    .byte_ready       (byte_ready),
    .q_full           (full),
    .q_push           (push),
    .q_data           (push_data)
  );

  // The queue lets the front end keep accepting while the output side drains a
  // bundle of several records.
  sqltl_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The output stage steps through the head bundle into a registered output word,
  // marking the final record of each bundle with last.
  sqltl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_head    (head),
    .q_pop     (pop),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_type  (rec_type),
    .text_byte (text_byte),
    .kind      (kind),
    .last      (last)
  );

endmodule
